// File: rtl/core/laplacian_variance_focus_search_assert.svh
// Assertion macros used by the focus search top level
`ifndef LAPLACIAN_VARIANCE_FOCUS_SEARCH_ASSERT_SVH
`define LAPLACIAN_VARIANCE_FOCUS_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
// a property that holds at every edge out of reset
`define LVFS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lvfs assertion failed");
// a property that holds whenever the condition is true
`define LVFS_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("lvfs assertion failed");
`else
`define LVFS_ASSERT(label, clk, rst_n, prop)
`define LVFS_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`endif
`endif

// File: rtl/core/lvfs_pkg.sv
package lvfs_pkg;

	// geometry and sweep limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_FRAMES = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// field widths
	localparam int DIM_W     = 11;
	localparam int STEP_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int FRAME_W   = 12;
	localparam int SUM_W     = 32;
	localparam int SQ_W      = 40;
	localparam int SCORE_W   = 60;
	localparam int POS_W     = 28;

	// frame statistics queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_POSITION_STEP = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       final_frame;
	} pixel_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic [SCORE_W-1:0] sharpness;
		logic [FRAME_W-1:0] best_frame;
		logic [POS_W-1:0]   best_position;
		logic               sweep_done;
	} result_t;

	// clamped geometry in use
	typedef struct packed {
		logic [COL_W:0] width;
		logic [ROW_W:0] height;
	} geom_t;

	// per-frame totals handed from front to back
	typedef struct packed {
		logic signed [SUM_W-1:0] lap_sum;
		logic [SQ_W-1:0]         lap_square_sum;
		geom_t                   geom;
		logic                    final_frame;
	} frame_stats_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic room;
	} q_status_t;

endpackage

// File: rtl/core/laplacian_variance_focus_search.sv
// Channel | Dir | Handshake             | Payload
// pixel   | in  | in_valid / in_ready   | in_data  (pixel_t: red, green, blue, final_frame)
// result  | out | out_valid / out_ready | out_data (result_t, one per frame)
// config  | in  | cfg_we                | cfg_index, cfg_data
//
// Pixels are taken at one per clock; in_ready drops only while the frame
// statistics queue holds QUEUE_DEPTH-1 frames or more.
// A frame's result is scored by the 8-state scoring sequencer from the totals that its
// last pixel transfer pushes into the queue; the sequencer then waits for out_ready.
// Reset is asynchronous; row buffers need no clearing pass.
// A stalled result holds in the sequencer while pixels keep flowing into the queue.
`include "laplacian_variance_focus_search_assert.svh"
module laplacian_variance_focus_search
	import lvfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pixel_t               in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] width_q, height_q;
	logic [STEP_W-1:0] step_q;
	geom_t geom;
	q_status_t q_status;
	logic q_push, q_pop;
	frame_stats_t push_data, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			step_q   <= STEP_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:   width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  height_q <= cfg_data[DIM_W-1:0];
				REG_POSITION_STEP: step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp geometry to the supported range
	always_comb begin
		if (width_q < DIM_W'(2)) begin
			geom.width = (COL_W+1)'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			geom.width = (COL_W+1)'(MAX_WIDTH);
		end else begin
			geom.width = (COL_W+1)'(width_q);
		end
		if (height_q < DIM_W'(2)) begin
			geom.height = (ROW_W+1)'(2);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			geom.height = (ROW_W+1)'(MAX_HEIGHT);
		end else begin
			geom.height = (ROW_W+1)'(height_q);
		end
	end

	lvfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.geom      (geom),
		.q_status  (q_status),
		.push      (q_push),
		.push_data (push_data)
	);

	lvfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.head      (head),
		.q_status  (q_status)
	);

	lvfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (q_pop),
		.step      (step_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// checks
	`LVFS_ASSERT_IMPLY(a_queue_no_overflow, clk, arst_n, q_push, !q_status.full)
	`LVFS_ASSERT_IMPLY(a_best_not_ahead, clk, arst_n, out_valid, out_data.best_frame <= out_data.frame_number)
	`LVFS_ASSERT(a_pos_only_done, clk, arst_n, !out_valid || out_data.sweep_done || out_data.best_position == '0)

endmodule

// File: rtl/core/lvfs_front.sv
module lvfs_front
	import lvfs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  pixel_t       in_data,
	input  geom_t        geom,
	input  q_status_t    q_status,
	output logic         push,
	output frame_stats_t push_data
);

	localparam int GRAY_R     = 4899;
	localparam int GRAY_G     = 9617;
	localparam int GRAY_B     = 1868;
	localparam int GRAY_ROUND = 8192;
	localparam int GRAY_SHIFT = 14;
	localparam int LAP_W      = 11;
	localparam int ROW_SUM_W  = 22;
	localparam int ROW_SQ_W   = 31;

	function automatic logic signed [LAP_W-1:0] lap5(input logic [7:0] up, input logic [7:0] down,
		input logic [7:0] left, input logic [7:0] right, input logic [7:0] mid);
		logic [9:0] ring;
		ring = 10'(up) + 10'(down) + 10'(left) + 10'(right);
		return $signed({1'b0, ring}) - $signed({1'b0, mid, 2'b00});
	endfunction

	function automatic logic [19:0] lap_sq(input logic signed [LAP_W-1:0] x);
		logic signed [2*LAP_W-1:0] p;
		p = x * x;
		return p[19:0];
	endfunction

	logic accept;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] w_m1;
	logic [ROW_W-1:0] h_m1;
	logic row_end, frame_end;
	logic [22:0] gray_full;
	logic [7:0] gray;
	logic [1:0] role_a_q, role_b_q, role_n_q;

	assign in_ready = q_status.room;
	assign accept   = in_valid && in_ready;

	// gray conversion
	assign gray_full = 23'(GRAY_R * in_data.red) + 23'(GRAY_G * in_data.green)
		+ 23'(GRAY_B * in_data.blue) + 23'(GRAY_ROUND);
	assign gray = gray_full[GRAY_SHIFT +: 8];

	// raster position
	assign w_m1      = COL_W'(geom.width - 1'b1);
	assign h_m1      = ROW_W'(geom.height - 1'b1);
	assign row_end   = col_q >= w_m1;
	assign frame_end = row_end && (row_q >= h_m1);

	// counters and row buffer roles: a = two rows up, b = previous, n = newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			role_a_q <= 2'd0;
			role_b_q <= 2'd1;
			role_n_q <= 2'd2;
		end else if (accept) begin
			if (!row_end) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q    <= '0;
				row_q    <= frame_end ? '0 : row_q + 1'b1;
				role_a_q <= role_b_q;
				role_b_q <= role_n_q;
				role_n_q <= role_a_q;
			end
		end
	end

	// three row buffers, registered read at the current column
	logic [7:0] line_mem [3][MAX_WIDTH];
	logic [7:0] line_rd_s1 [3];

	for (genvar k = 0; k < 3; k++) begin : g_line
		always_ff @(posedge clk) begin
			if (accept) begin
				if (role_n_q == 2'(k)) begin
					line_mem[k][col_q] <= gray;
				end
				line_rd_s1[k] <= line_mem[k][col_q];
			end
		end
	end

	// stage 1
	logic valid_s1, first_s1, col1_s1, row_end_s1, last_s1, final_s1, rows_on_s1, up_new_s1;
	logic [7:0] gray_s1;
	logic [1:0] role_a_s1, role_b_s1;
	geom_t geom_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1    <= gray;
			first_s1   <= col_q == '0;
			col1_s1    <= col_q == COL_W'(1);
			row_end_s1 <= row_end;
			last_s1    <= frame_end;
			final_s1   <= in_data.final_frame;
			rows_on_s1 <= row_q != '0;
			up_new_s1  <= row_q == ROW_W'(1);
			role_a_s1  <= role_a_q;
			role_b_s1  <= role_b_q;
			geom_s1    <= geom;
		end
	end

	// Laplacian of the previous column and, at row end, of the last column.
	// Stream a: middle row is the previous row. Stream b: the newest row, used
	// only if this turns out to be the frame's last row.
	logic [7:0] a_c, b_c;
	logic [7:0] am1_q, bm1_q, bm2_q, nm1_q, nm2_q;
	logic prev_en, end_en;
	logic signed [LAP_W-1:0] lap_ap, lap_ae, lap_bp, lap_be;

	assign a_c     = line_rd_s1[role_a_s1];
	assign b_c     = line_rd_s1[role_b_s1];
	assign prev_en = valid_s1 && rows_on_s1 && !first_s1;
	assign end_en  = valid_s1 && rows_on_s1 && row_end_s1;

	always_comb begin
		lap_ap = prev_en ? lap5(up_new_s1 ? nm1_q : am1_q, nm1_q,
			col1_s1 ? b_c : bm2_q, b_c, bm1_q) : '0;
		lap_bp = prev_en ? lap5(bm1_q, bm1_q, col1_s1 ? gray_s1 : nm2_q, gray_s1, nm1_q) : '0;
		lap_ae = end_en ? lap5(up_new_s1 ? gray_s1 : a_c, gray_s1, bm1_q, bm1_q, b_c) : '0;
		lap_be = end_en ? lap5(b_c, b_c, nm1_q, nm1_q, gray_s1) : '0;
	end

	// column history
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			am1_q <= a_c;
			bm2_q <= bm1_q;
			bm1_q <= b_c;
			nm2_q <= nm1_q;
			nm1_q <= gray_s1;
		end
	end

	// stage 2
	logic valid_s2, row_end_s2, last_s2, final_s2;
	logic signed [LAP_W-1:0] lap_ap_s2, lap_ae_s2, lap_bp_s2, lap_be_s2;
	geom_t geom_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			lap_ap_s2  <= lap_ap;
			lap_ae_s2  <= lap_ae;
			lap_bp_s2  <= lap_bp;
			lap_be_s2  <= lap_be;
			row_end_s2 <= row_end_s1;
			last_s2    <= last_s1;
			final_s2   <= final_s1;
			geom_s2    <= geom_s1;
		end
	end

	// accumulation: frame totals, plus last-row candidate totals per row
	logic signed [LAP_W:0] a_sum, b_sum;
	logic [20:0] a_sq, b_sq;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0] sumsq_q;
	logic signed [ROW_SUM_W-1:0] tsum_q;
	logic [ROW_SQ_W-1:0] tsq_q;

	assign a_sum = (LAP_W+1)'(lap_ap_s2) + (LAP_W+1)'(lap_ae_s2);
	assign b_sum = (LAP_W+1)'(lap_bp_s2) + (LAP_W+1)'(lap_be_s2);
	assign a_sq  = 21'(lap_sq(lap_ap_s2)) + 21'(lap_sq(lap_ae_s2));
	assign b_sq  = 21'(lap_sq(lap_bp_s2)) + 21'(lap_sq(lap_be_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
			tsum_q  <= '0;
			tsq_q   <= '0;
		end else if (valid_s2) begin
			priority if (last_s2) begin
				sum_q   <= '0;
				sumsq_q <= '0;
				tsum_q  <= '0;
				tsq_q   <= '0;
			end else if (row_end_s2) begin
				sum_q   <= sum_q + SUM_W'(a_sum);
				sumsq_q <= sumsq_q + SQ_W'(a_sq);
				tsum_q  <= '0;
				tsq_q   <= '0;
			end else begin
				sum_q   <= sum_q + SUM_W'(a_sum);
				sumsq_q <= sumsq_q + SQ_W'(a_sq);
				tsum_q  <= tsum_q + ROW_SUM_W'(b_sum);
				tsq_q   <= tsq_q + ROW_SQ_W'(b_sq);
			end
		end
	end

	// frame totals out to the queue
	assign push = valid_s2 && last_s2;
	always_comb begin
		push_data.lap_sum = sum_q + SUM_W'(a_sum) + SUM_W'(tsum_q) + SUM_W'(b_sum);
		push_data.lap_square_sum = sumsq_q + SQ_W'(a_sq) + SQ_W'(tsq_q) + SQ_W'(b_sq);
		push_data.geom = geom_s2;
		push_data.final_frame = final_s2;
	end

endmodule

// File: rtl/core/lvfs_queue.sv
module lvfs_queue
	import lvfs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frame_stats_t push_data,
	input  logic         pop,
	output frame_stats_t head,
	output q_status_t    q_status
);

	frame_stats_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head = entry_q[rd_ptr_q];

	// room keeps a slot free for a frame end still in the front pipeline
	assign q_status.full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_status.empty = count_q == '0;
	assign q_status.room  = count_q < (QPTR_W+1)'(QUEUE_DEPTH - 1);

endmodule

// File: rtl/core/lvfs_back.sv
module lvfs_back
	import lvfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  q_status_t         q_status,
	input  frame_stats_t      head,
	output logic              pop,
	input  logic [STEP_W-1:0] step,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_data
);

	localparam int N_W    = COL_W + ROW_W + 2;
	localparam int HALF_W = SQ_W / 2;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_N  = 8'b0000_0010,
		ST_MUL_LO = 8'b0000_0100,
		ST_MUL_HI = 8'b0000_1000,
		ST_SUM    = 8'b0001_0000,
		ST_BEST   = 8'b0010_0000,
		ST_POS    = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;
	frame_stats_t job_q;
	logic [N_W-1:0] n_q;
	logic [SCORE_W-1:0] sq_q, score_q, best_score_q;
	logic [N_W+HALF_W-1:0] plo_q, phi_q;
	logic [FRAME_W-1:0] frame_cnt_q, best_idx_q;
	result_t result_q;

	logic [SUM_W-1:0] mag;
	logic [2*SUM_W-1:0] sq_full;
	logic [N_W-1:0] n_full;
	logic [N_W+HALF_W-1:0] part;
	logic [SCORE_W+1:0] prod;
	logic take;
	logic [POS_W-1:0] pos_full;

	assign pop = (state_q == ST_IDLE) && !q_status.empty;

	// arithmetic, with the multipliers used in ST_MUL_N, ST_MUL_LO, ST_MUL_HI and ST_POS
	assign mag      = job_q.lap_sum[SUM_W-1] ? SUM_W'(-job_q.lap_sum) : SUM_W'(job_q.lap_sum);
	assign sq_full  = mag * mag;
	assign n_full   = N_W'(job_q.geom.width) * N_W'(job_q.geom.height);
	assign part     = n_q * ((state_q == ST_MUL_LO) ? job_q.lap_square_sum[HALF_W-1:0]
		: job_q.lap_square_sum[SQ_W-1:HALF_W]);
	assign prod     = (SCORE_W+2)'(plo_q) + ((SCORE_W+2)'(phi_q) << HALF_W);
	assign take     = (frame_cnt_q == '0) || (score_q > best_score_q);
	assign pos_full = best_idx_q * step;

	// sequencer and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_cnt_q  <= '0;
			best_idx_q   <= '0;
			best_score_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						state_q <= ST_MUL_N;
					end
				end
				ST_MUL_N:  state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_BEST;
				ST_BEST: begin
					if (take) begin
						best_score_q <= score_q;
						best_idx_q   <= frame_cnt_q;
					end
					state_q <= ST_POS;
				end
				ST_POS: begin
					if (job_q.final_frame) begin
						frame_cnt_q  <= '0;
						best_idx_q   <= '0;
						best_score_q <= '0;
					end else if (frame_cnt_q < FRAME_W'(MAX_FRAMES - 1)) begin
						frame_cnt_q <= frame_cnt_q + 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					job_q <= head;
				end
			end
			ST_MUL_N: begin
				n_q  <= n_full;
				sq_q <= SCORE_W'(sq_full);
			end
			ST_MUL_LO: plo_q <= part;
			ST_MUL_HI: phi_q <= part;
			ST_SUM: begin
				score_q <= (prod > (SCORE_W+2)'(sq_q)) ? SCORE_W'(prod - (SCORE_W+2)'(sq_q)) : '0;
			end
			ST_BEST: begin
				result_q.frame_number <= frame_cnt_q;
				result_q.sharpness    <= score_q;
				result_q.best_frame   <= take ? frame_cnt_q : best_idx_q;
				result_q.sweep_done   <= job_q.final_frame;
			end
			ST_POS: begin
				result_q.best_position <= job_q.final_frame ? pos_full : '0;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	assign out_valid = state_q == ST_OUT;
	assign out_data  = result_q;

endmodule

// File: tb/sharpness_checker.sv
`timescale 1ns / 1ps
module sharpness_checker
	import lvfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  pixel_t               in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  result_t              out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	typedef enum int {LINE_ABOVE, LINE_MID, LINE_NEW} line_sel_t;

	localparam logic [63:0] SCORE_MASK = 64'h0FFF_FFFF_FFFF_FFFF;

	// register copies
	logic [10:0] width_reg;
	logic [10:0] height_reg;
	logic [15:0] step_reg;

	// gray line buffers and frame totals
	logic [7:0]         line_above [MAX_WIDTH];
	logic [7:0]         line_mid   [MAX_WIDTH];
	logic [7:0]         line_new   [MAX_WIDTH];
	int                 col_pos;
	int                 row_pos;
	logic signed [63:0] lap_total;
	logic [63:0]        lap_sq_total;
	int                 frame_idx;
	logic [63:0]        top_score;
	int                 top_idx;

	result_t sharpness_q[$];

	function automatic int clamp_dim(input logic [10:0] v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic int gray_at(input line_sel_t sel, input int c);
		case (sel)
			LINE_ABOVE: return int'(line_above[c]);
			LINE_MID:   return int'(line_mid[c]);
			default:    return int'(line_new[c]);
		endcase
	endfunction

	// accumulate one row of Laplacian values, mirrored at the row ends
	function automatic void add_laplacian_row(input line_sel_t up, input line_sel_t mid,
			input line_sel_t down, input int w);
		int          left;
		int          right;
		int          lap;
		logic [63:0] lap64;
		for (int c = 0; c < w; c++) begin
			left  = (c == 0) ? gray_at(mid, 1) : gray_at(mid, c - 1);
			right = (c == w - 1) ? gray_at(mid, w - 2) : gray_at(mid, c + 1);
			lap   = gray_at(up, c) + gray_at(down, c) + left + right - 4 * gray_at(mid, c);
			lap64 = 64'(signed'(lap * lap));
			lap_total    += 64'(signed'(lap));
			lap_sq_total += lap64;
		end
	endfunction

	function automatic void shift_lines();
		for (int c = 0; c < MAX_WIDTH; c++) begin
			line_above[c] = line_mid[c];
			line_mid[c]   = line_new[c];
		end
	endfunction

	// one accepted pixel; returns 1 when it closes a frame
	function automatic bit predict_pixel(input pixel_t p, output result_t r);
		int          w;
		int          h;
		int          col;
		int          gray;
		logic [63:0] n;
		logic [63:0] mag;
		logic [63:0] sq;
		logic [63:0] prod;
		logic [63:0] score;
		w    = clamp_dim(width_reg, MAX_WIDTH);
		h    = clamp_dim(height_reg, MAX_HEIGHT);
		col  = col_pos % MAX_WIDTH;
		gray = (4899 * int'(p.red) + 9617 * int'(p.green) + 1868 * int'(p.blue) + 8192) >> 14;
		r    = '0;
		line_new[col] = gray[7:0];
		if (col < w - 1) begin
			col_pos = col + 1;
			return 1'b0;
		end
		col_pos = 0;
		if (row_pos == 1)
			add_laplacian_row(LINE_NEW, LINE_MID, LINE_NEW, w);
		else if (row_pos >= 2)
			add_laplacian_row(LINE_ABOVE, LINE_MID, LINE_NEW, w);
		if (row_pos < h - 1) begin
			shift_lines();
			row_pos++;
			return 1'b0;
		end
		// last row: the row below mirrors to the row above
		if (row_pos == 0)
			add_laplacian_row(LINE_NEW, LINE_NEW, LINE_NEW, w);
		else
			add_laplacian_row(LINE_MID, LINE_NEW, LINE_MID, w);
		shift_lines();
		row_pos = 0;

		n     = 64'(w) * 64'(h);
		mag   = (lap_total < 0) ? 64'(-lap_total) : 64'(lap_total);
		sq    = mag * mag;
		prod  = n * lap_sq_total;
		score = (prod > sq) ? ((prod - sq) & SCORE_MASK) : 64'd0;
		lap_total    = 0;
		lap_sq_total = 0;
		if (frame_idx == 0 || score > top_score) begin
			top_score = score;
			top_idx   = frame_idx;
		end
		r.frame_number  = frame_idx[FRAME_W-1:0];
		r.sharpness     = score[SCORE_W-1:0];
		r.best_frame    = top_idx[FRAME_W-1:0];
		r.best_position = p.final_frame ? POS_W'(64'(top_idx) * 64'(step_reg)) : '0;
		r.sweep_done    = p.final_frame;
		if (frame_idx < MAX_FRAMES - 1) frame_idx++;
		if (p.final_frame) begin
			frame_idx = 0;
			top_score = 0;
			top_idx   = 0;
		end
		return 1'b1;
	endfunction

	// watch config, pixel and result transfers
	always @(posedge clk or negedge arst_n) begin
		result_t r;
		result_t e;
		if (!arst_n) begin
			width_reg    <= 11'd640;
			height_reg   <= 11'd480;
			step_reg     <= 16'd10;
			col_pos      = 0;
			row_pos      = 0;
			lap_total    = 0;
			lap_sq_total = 0;
			frame_idx    = 0;
			top_score    = 0;
			top_idx      = 0;
			mismatches   = 0;
			sharpness_q.delete();
			for (int c = 0; c < MAX_WIDTH; c++) begin
				line_above[c] = '0;
				line_mid[c]   = '0;
				line_new[c]   = '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_WIDTH:   width_reg  <= cfg_data[10:0];
					REG_FRAME_HEIGHT:  height_reg <= cfg_data[10:0];
					REG_POSITION_STEP: step_reg   <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (predict_pixel(in_data, r)) sharpness_q = {sharpness_q, r};
			end
			if (out_valid && out_ready) begin
				if (sharpness_q.size() == 0) begin
					$error("result transfer with nothing expected");
					mismatches++;
				end else begin
					e = sharpness_q.pop_front();
					if (out_data.frame_number !== e.frame_number) begin
						$error("frame_number expected %0d got %0d",
							e.frame_number, out_data.frame_number);
						mismatches++;
					end
					if (out_data.sharpness !== e.sharpness) begin
						$error("sharpness expected %0d got %0d", e.sharpness, out_data.sharpness);
						mismatches++;
					end
					if (out_data.best_frame !== e.best_frame) begin
						$error("best_frame expected %0d got %0d", e.best_frame, out_data.best_frame);
						mismatches++;
					end
					if (out_data.best_position !== e.best_position) begin
						$error("best_position expected %0d got %0d",
							e.best_position, out_data.best_position);
						mismatches++;
					end
					if (out_data.sweep_done !== e.sweep_done) begin
						$error("sweep_done expected %0d got %0d", e.sweep_done, out_data.sweep_done);
						mismatches++;
					end
				end
			end
		end
		outstanding = sharpness_q.size();
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import lvfs_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	pixel_t               in_data;
	logic                 out_valid;
	logic                 out_ready;
	result_t              out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   max_gap;
	int                   pixels_sent;
	int                   cur_w;
	int                   cur_h;

	laplacian_variance_focus_search DUT (.*);

	sharpness_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// one pixel transfer, preceded by a random gap
	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// hold the pixel side until every result is in, then let the sequencer settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_geometry(input int w, input int h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		cur_w = (w < 2) ? 2 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
		cur_h = (h < 2) ? 2 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
	endtask

	// style: 0 random, 1 flat value v, 2 checkerboard, 3 pure colour v
	task automatic send_frame(input int style, input int v, input bit last);
		pixel_t p;
		for (int y = 0; y < cur_h; y++) begin
			for (int x = 0; x < cur_w; x++) begin
				case (style)
					1: p = {8'(v), 8'(v), 8'(v), 1'b0};
					2: p = ((x + y) % 2 == 1) ? {8'hff, 8'hff, 8'hff, 1'b0} : '0;
					3: p = {(v == 0) ? 8'hff : 8'h00, (v == 1) ? 8'hff : 8'h00,
						(v == 2) ? 8'hff : 8'h00, 1'b0};
					default: begin
						case ($urandom_range(0, 3))
							0: p = {$urandom_range(0, 1) ? 8'hff : 8'h00,
								$urandom_range(0, 1) ? 8'hff : 8'h00,
								$urandom_range(0, 1) ? 8'hff : 8'h00, 1'b0};
							default: p = {8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
						endcase
					end
				endcase
				// the flag only counts on the frame's last pixel
				p.final_frame = (x == cur_w - 1 && y == cur_h - 1) ? last : 1'($urandom);
				send_pixel(p);
			end
		end
	endtask

	// result side: random stalls and one long hold-off
	initial begin
		int stall;
		int taken;
		out_ready = 1'b0;
		taken     = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = (taken == 2) ? 400 : $urandom_range(0, 9);
			if ((taken / 100) % 3 == 2) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		int nframes;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_FRAME_WIDTH;
		cfg_data    = '0;
		max_gap     = 9;
		pixels_sent = 0;
		arst_n      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: smallest frames, flat, checkerboard, colours, a tie
		set_geometry(2, 2);
		write_reg(REG_POSITION_STEP, 65535);
		send_frame(1, 0, 1'b0);
		send_frame(2, 0, 1'b0);
		send_frame(2, 0, 1'b0);
		send_frame(1, 255, 1'b0);
		send_frame(3, 0, 1'b0);
		// keep offering frames while the result side holds off
		for (int f = 0; f < 10; f++) send_frame(0, 0, 1'b0);
		send_frame(3, 1, 1'b1);
		drain();
		write_reg(REG_POSITION_STEP, 0);
		send_frame(3, 2, 1'b0);
		send_frame(2, 0, 1'b1);
		drain();

		// random sweeps of random small geometry
		while (pixels_sent < 1900) begin
			set_geometry($urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(2, 8),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(2, 6));
			write_reg(REG_POSITION_STEP, $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535));
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
			nframes = $urandom_range(1, 8);
			for (int f = 0; f < nframes; f++)
				send_frame(0, 0, (f == nframes - 1) || ($urandom_range(0, 7) == 0));
			drain();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lvfs_pkg.sv
rtl/core/lvfs_front.sv
rtl/core/lvfs_queue.sv
rtl/core/lvfs_back.sv
rtl/core/laplacian_variance_focus_search.sv
tb/sharpness_checker.sv
tb/tb.sv
